/* design/bsac_pkg.sv */
// Shared constants and types for the bounded-step array counter.
package bsac_pkg;

  localparam int unsigned ValueW = 8;
  localparam int unsigned WaysW = 30;
  localparam int unsigned SumW = WaysW + 2;

  localparam logic [SumW-1:0] WaysMod = 32'd1000000007;
  localparam logic [SumW-1:0] WaysMod2 = 32'd2000000014;

  typedef struct packed {
    logic load;
    logic seed;
    logic shift;
  } cell_ctrl_t;

endpackage

/* design/bsac_cell.sv */
// One cell of the count chain: holds the number of ways ending at its own value.
module bsac_cell import bsac_pkg::*; #(
  parameter int unsigned MW = 8,
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [ValueW-1:0] value_i,
  input  logic [MW-1:0]     m_i,
  input  logic [WaysW-1:0]  left_i,
  input  logic [WaysW-1:0]  right_i,
  output logic [WaysW-1:0]  count_o
);

  localparam int unsigned CW = ((MW > ValueW) ? MW : ValueW) + 1;
  localparam logic [CW-1:0] SelfVal = CW'(IDX + 1);
  localparam logic [CW-1:0] RightVal = CW'(IDX + 2);

  logic [WaysW-1:0] count_q, count_d;
  logic [CW-1:0]    m_ext;
  logic [CW-1:0]    value_ext;
  logic             active;
  logic             right_ok;
  logic [SumW-1:0]  sum;
  logic [WaysW-1:0] reduced;

  assign m_ext = CW'(m_i);
  assign value_ext = CW'(value_i);
  assign active = (SelfVal <= m_ext) && ((value_i == '0) || (value_ext == SelfVal));
  assign right_ok = (RightVal <= m_ext);

  always_comb begin
    sum = SumW'(count_q) + SumW'(left_i) + (right_ok ? SumW'(right_i) : '0);
    if (sum >= WaysMod2) begin
      reduced = WaysW'(sum - WaysMod2);
    end else if (sum >= WaysMod) begin
      reduced = WaysW'(sum - WaysMod);
    end else begin
      reduced = WaysW'(sum);
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.shift) begin
      count_d = right_i;
    end else if (ctrl_i.load) begin
      if (!active) begin
        count_d = '0;
      end else if (ctrl_i.seed) begin
        count_d = WaysW'(1);
      end else begin
        count_d = reduced;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
  end

  assign count_o = count_q;

endmodule

/* design/bounded_step_array_counter_top.sv */
// Top level of the bounded-step array counter: cell chain, summing pass and output register.
//
// Array elements arrive on the input channel (value_i, last_i) under in_valid_i and
// in_ready_o. A value of zero is free; any other value fixes the element. Every cell
// of the chain updates its count from its neighbours in the cycle the element is
// taken, so elements without last_i are accepted one per clock cycle.
// An element with last_i set starts a summing pass: the counts shift down the chain
// into an accumulator, one cell per cycle, until all MAX_VALUES counts are summed.
// During the pass in_ready_o is low. The total then enters the output register and is
// offered on total_ways_o under out_valid_o; the next array may begin in the following
// cycle. An element with last_i therefore occupies the block until its pass ends.
// If the receiver holds out_ready_i low, the output register keeps its result and
// further elements are still accepted; a later pass waits at its final step until
// the register is free. The max_value register is written through max_value_we_i and
// max_value_i with no wait state. Reset sets max_value to 128, empties the output
// register and marks the next element as the first of an array; the counts need no
// clearing, because the first element of an array seeds every cell.
module bounded_step_array_counter_top import bsac_pkg::*; #(
  parameter int unsigned MAX_VALUES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              max_value_we_i,
  input  logic [ValueW-1:0] max_value_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ValueW-1:0] value_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WaysW-1:0]  total_ways_o
);

  localparam int unsigned MW = $clog2(MAX_VALUES + 1);
  localparam int unsigned CMW = (MW > ValueW) ? MW : ValueW;
  localparam int unsigned CntW = $clog2(MAX_VALUES);
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_VALUES - 1);

  typedef enum logic {
    StIdle,
    StSum
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;
  logic [WaysW-1:0]  acc_q;
  logic [WaysW-1:0]  total_q;
  logic              out_valid_q;
  logic              at_start_q;
  logic [ValueW-1:0] max_value_q;

  logic [CMW-1:0]    max_ext;
  logic [CMW-1:0]    m_eff;
  logic [MW-1:0]     m_w;
  logic              in_fire;
  logic              out_fire;
  logic              cnt_at_last;
  logic              advance;
  logic [WaysW:0]    acc_sum;
  logic [WaysW-1:0]  acc_next;
  cell_ctrl_t        ctrl;
  logic [WaysW-1:0]  count_w [MAX_VALUES];

  assign max_ext = CMW'(max_value_q);
  assign m_eff = (max_ext > CMW'(MAX_VALUES)) ? CMW'(MAX_VALUES) : max_ext;
  assign m_w = m_eff[MW-1:0];

  assign in_ready_o = (state_q == StIdle);
  assign in_fire = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign cnt_at_last = (cnt_q == CntLast);
  assign advance = (state_q == StSum) && !(cnt_at_last && out_valid_q && !out_ready_i);

  assign acc_sum = (WaysW + 1)'(acc_q) + (WaysW + 1)'(count_w[0]);
  assign acc_next = (acc_sum >= (WaysW + 1)'(WaysMod)) ?
                    WaysW'(acc_sum - (WaysW + 1)'(WaysMod)) : WaysW'(acc_sum);

  assign ctrl.load = in_fire;
  assign ctrl.seed = at_start_q;
  assign ctrl.shift = advance;

  for (genvar j = 0; j < MAX_VALUES; j++) begin : g_cell
    logic [WaysW-1:0] left_w;
    logic [WaysW-1:0] right_w;
    if (j == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = count_w[j-1];
    end
    if (j == MAX_VALUES - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = count_w[j+1];
    end
    bsac_cell #(
      .MW  (MW),
      .IDX (j)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (value_i),
      .m_i     (m_w),
      .left_i  (left_w),
      .right_i (right_w),
      .count_o (count_w[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= ValueW'(128);
    end else if (max_value_we_i) begin
      max_value_q <= max_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      acc_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      at_start_q  <= 1'b1;
    end else begin
      if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            at_start_q <= last_i;
            if (last_i) begin
              state_q <= StSum;
              cnt_q   <= '0;
              acc_q   <= '0;
            end
          end
        end
        StSum: begin
          if (advance) begin
            if (cnt_at_last) begin
              total_q     <= acc_next;
              out_valid_q <= 1'b1;
              cnt_q       <= '0;
              state_q     <= StIdle;
            end else begin
              acc_q <= acc_next;
              cnt_q <= cnt_q + CntW'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign total_ways_o = total_q;

`ifndef SYNTHESIS
  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> !in_ready_o)
    else $error("Input still accepted after a closing transaction.");

  a_result_from_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StSum))
    else $error("Result appeared without a summing pass.");

  a_total_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (SumW'(total_ways_o) < WaysMod))
    else $error("Total is not reduced below the modulus.");

  a_idle_counter_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (cnt_q == '0))
    else $error("Pass counter not cleared while idle.");

  a_next_is_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSum) |-> at_start_q)
    else $error("Summing pass without the next element marked first.");
`endif

endmodule

/* bench/tb.sv */
// Self-checking testbench for the bounded-step array counter with a predictor of array totals.
module tb import bsac_pkg::*; ();

  localparam int unsigned MaxValues = 128;
  localparam longint unsigned TotalMod = 64'd1000000007;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = MaxValues + 8;
  localparam int unsigned RandomItems = 1250;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
  } element_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              max_value_we_i = 1'b0;
  logic [ValueW-1:0] max_value_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ValueW-1:0] value_i = '0;
  logic              last_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WaysW-1:0]  total_ways_o;

  element_t         element_queue[$];
  logic [WaysW-1:0] expected_totals[$];

  logic [WaysW-1:0] ways_at[MaxValues];
  logic             array_first = 1'b1;
  logic [ValueW-1:0] limit_reg = 8'd128;

  logic        item_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  logic        in_calm = 1'b0;
  logic        out_calm = 1'b0;

  int unsigned mismatches = 0;
  int unsigned elements_taken = 0;
  int unsigned totals_checked = 0;
  int unsigned settings_used = 0;
  int unsigned cycles = 0;

  bounded_step_array_counter_top #(
    .MAX_VALUES(MaxValues)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_value_we_i(max_value_we_i),
    .max_value_i   (max_value_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .total_ways_o  (total_ways_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic advance_ways(input logic [ValueW-1:0] v, input logic is_last);
    logic [WaysW-1:0] next_ways[MaxValues];
    int unsigned      m;
    int unsigned      cell_val;
    longint unsigned  s;
    longint unsigned  total;
    m = (limit_reg > MaxValues) ? MaxValues : limit_reg;
    for (int j = 0; j < MaxValues; j++) begin
      cell_val = j + 1;
      next_ways[j] = '0;
      if (cell_val <= m && (v == 0 || v == cell_val)) begin
        if (array_first) begin
          next_ways[j] = WaysW'(1);
        end else begin
          s = ways_at[j];
          if (j >= 1) begin
            s += ways_at[j-1];
          end
          if (cell_val + 1 <= m && j + 1 < MaxValues) begin
            s += ways_at[j+1];
          end
          next_ways[j] = WaysW'(s % TotalMod);
        end
      end
    end
    ways_at = next_ways;
    if (is_last) begin
      total = 0;
      for (int j = 0; j < MaxValues; j++) begin
        total = (total + ways_at[j]) % TotalMod;
      end
      expected_totals = {expected_totals, WaysW'(total)};
      array_first = 1'b1;
    end else begin
      array_first = 1'b0;
    end
  endtask

  // The driver offers the next pending element at the falling edge once any gap has elapsed.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || item_taken) begin
      item_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (element_queue.size() > 0) begin
        element_t e;
        e = element_queue.pop_front();
        value_i    <= e.value;
        last_i     <= e.last;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 63) == 0) begin
          in_calm = ~in_calm;
        end
        in_gap = in_calm ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 63) == 0) begin
        out_calm = ~out_calm;
      end
      out_stall = out_calm ? 0 : pick_gap();
    end
  end

  // The monitor predicts on each accepted element and checks each accepted total.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d totals outstanding.",
               cycles, expected_totals.size());
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni) begin
      if (max_value_we_i) begin
        limit_reg = max_value_i;
      end
      if (in_valid_i && in_ready_o) begin
        item_taken = 1'b1;
        elements_taken++;
        advance_ways(value_i, last_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_totals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result transaction: total_ways %0d", total_ways_o);
          end
        end else begin
          logic [WaysW-1:0] want;
          want = expected_totals.pop_front();
          totals_checked++;
          if (total_ways_o !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch on total_ways: expected %0d, actual %0d", want, total_ways_o);
            end
          end
        end
      end
    end
  end

  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (element_queue.size() != 0 || in_valid_i || expected_totals.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [ValueW-1:0] v);
    wait_idle();
    max_value_we_i <= 1'b1;
    max_value_i    <= v;
    @(negedge clk_i);
    max_value_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic push_element(input logic [ValueW-1:0] v, input logic is_last);
    element_t e;
    e.value = v;
    e.last  = is_last;
    element_queue = {element_queue, e};
  endtask

  task automatic fill_random_phase(input int unsigned m_eff, input int unsigned n,
                                   inout int unsigned produced);
    int unsigned count;
    int unsigned len;
    int unsigned pos;
    int unsigned r;
    logic [ValueW-1:0] v;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 9);
      len = (r < 6) ? $urandom_range(1, 6) : (r < 9) ? $urandom_range(7, 20)
                                                      : $urandom_range(21, 60);
      pos = (m_eff == 0) ? 1 : $urandom_range(1, m_eff);
      for (int unsigned k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          v = '0;
        end else if (r < 90) begin
          v = ValueW'(pos);
        end else begin
          v = ValueW'($urandom_range(0, 255));
        end
        push_element(v, k == len - 1);
        r = $urandom_range(0, 2);
        if (r == 0 && pos > 1) begin
          pos--;
        end else if (r == 2 && pos < m_eff) begin
          pos++;
        end
        count++;
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      len = $urandom_range(1, 4);
      for (int unsigned k = 0; k < len; k++) begin
        push_element(ValueW'($urandom_range(0, 1) ? 0 : $urandom_range(1, 255)), 1'b0);
        count++;
      end
    end
    produced += count;
  endtask

  initial begin
    int unsigned produced;
    int unsigned r;
    logic [ValueW-1:0] lim;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    push_element(8'd0, 1'b1);
    push_element(8'd1, 1'b1);
    push_element(8'd128, 1'b1);
    push_element(8'd129, 1'b1);
    push_element(8'd255, 1'b1);
    push_element(8'd0, 1'b0);
    push_element(8'd0, 1'b0);
    push_element(8'd0, 1'b1);
    push_element(8'd1, 1'b0);
    push_element(8'd3, 1'b1);
    push_element(8'd128, 1'b0);
    push_element(8'd0, 1'b0);
    push_element(8'd127, 1'b1);

    write_limit(8'd1);
    push_element(8'd0, 1'b0);
    push_element(8'd0, 1'b1);
    push_element(8'd2, 1'b1);

    write_limit(8'd0);
    push_element(8'd0, 1'b1);
    push_element(8'd5, 1'b0);
    push_element(8'd0, 1'b1);

    write_limit(8'd255);
    push_element(8'd0, 1'b0);
    push_element(8'd128, 1'b1);
    push_element(8'd0, 1'b0);
    push_element(8'd100, 1'b0);

    // The pending array continues under a smaller limit.
    write_limit(8'd3);
    push_element(8'd0, 1'b1);

    produced = 0;
    while (produced < RandomItems) begin
      r = $urandom_range(0, 19);
      case (r)
        0: lim = 8'd0;
        1: lim = 8'd1;
        2: lim = 8'd128;
        3: lim = 8'd255;
        4: lim = ValueW'($urandom_range(129, 255));
        5, 6, 7, 8, 9: lim = ValueW'($urandom_range(2, 8));
        default: lim = ValueW'($urandom_range(1, 128));
      endcase
      write_limit(lim);
      fill_random_phase((lim > MaxValues) ? MaxValues : lim, $urandom_range(40, 120), produced);
    end

    wait_idle();
    mismatches += expected_totals.size();
    $display("Covered %0d array elements and %0d checked totals over %0d max_value settings.",
             elements_taken, totals_checked, settings_used);
    $display("Mismatches counted: %0d in %0d cycles.", mismatches, cycles);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* filelist.f */
design/bsac_pkg.sv
design/bsac_cell.sv
design/bounded_step_array_counter_top.sv
bench/tb.sv
